// File: hdl/cse_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cse_pkg
// types and constants shared by the cosine similarity engine
// ---------------------------------------------------------------------------
package cse_pkg;

  localparam int ELEMENT_WIDTH = 16;
  localparam int DOT_WIDTH     = 43;
  localparam int NORM_WIDTH    = 42;
  localparam int FLOOR_WIDTH   = 32;
  localparam int SIM_WIDTH     = 16;
  localparam int DIGIT_WIDTH   = 8;
  localparam int MUL_STEPS     = 6;
  localparam int ROOT_STEPS    = SIM_WIDTH;
  localparam int MCAND_WIDTH   = 88;
  localparam int MPLIER_WIDTH  = MUL_STEPS * DIGIT_WIDTH;
  localparam int DSQ_WIDTH     = 86;
  localparam int PROD_WIDTH    = 84;
  localparam int ROOT_WIDTH    = 118;
  localparam int COUNT_WIDTH   = 4;
  localparam logic [FLOOR_WIDTH-1:0] FLOOR_RESET = 32'd11;

  typedef struct packed {
    logic signed [ELEMENT_WIDTH-1:0] a_value;
    logic signed [ELEMENT_WIDTH-1:0] b_value;
    logic                            last;
  } item_t;

  typedef struct packed {
    logic [SIM_WIDTH-1:0] similarity;
    logic                 degenerate;
    logic                 saturated;
  } result_t;

  typedef struct packed {
    logic accum;
    logic load;
    logic mul_step;
    logic root_init;
    logic root_step;
  } ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_RINIT,
    ST_ROOT,
    ST_DONE
  } state_t;

endpackage

// File: hdl/cse_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cse_datapath
// accumulators, digit-serial multipliers and bitwise root search
// ---------------------------------------------------------------------------
module cse_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  cse_pkg::ctrl_t                   cmd,
  input  cse_pkg::item_t                   item,
  input  logic                             cfg_write,
  input  logic [cse_pkg::FLOOR_WIDTH-1:0]  cfg_data,
  output cse_pkg::result_t                 result
);
  import cse_pkg::*;

  logic [FLOOR_WIDTH-1:0]       norm_floor_sq;
  logic signed [DOT_WIDTH-1:0]  dot;
  logic [NORM_WIDTH-1:0]        norm_a;
  logic [NORM_WIDTH-1:0]        norm_b;
  logic                         overflow_seen;

  logic [MCAND_WIDTH-1:0]       mcand_d, mcand_p, prod_d, prod_p;
  logic [MPLIER_WIDTH-1:0]      mplier_d, mplier_p;
  logic [ROOT_WIDTH-1:0]        acc_s, acc_u, acc_v;
  logic [SIM_WIDTH-1:0]         q;
  logic                         zero_res, degen, sat_r;

  logic signed [2*ELEMENT_WIDTH-1:0] p_ab, p_aa, p_bb;
  logic signed [DOT_WIDTH:0]    dot_sum;
  logic [NORM_WIDTH:0]          na_sum, nb_sum;
  logic                         dot_pos, degen_now;
  logic [ROOT_WIDTH-1:0]        cand, target;
  logic                         ok;

  assign p_ab    = item.a_value * item.b_value;
  assign p_aa    = item.a_value * item.a_value;
  assign p_bb    = item.b_value * item.b_value;
  assign dot_sum = {dot[DOT_WIDTH-1], dot} + (DOT_WIDTH+1)'(p_ab);
  assign na_sum  = {1'b0, norm_a} + (NORM_WIDTH+1)'(p_aa[2*ELEMENT_WIDTH-2:0]);
  assign nb_sum  = {1'b0, norm_b} + (NORM_WIDTH+1)'(p_bb[2*ELEMENT_WIDTH-2:0]);

  assign dot_pos   = !dot[DOT_WIDTH-1] && (dot != '0);
  assign degen_now = (norm_a < NORM_WIDTH'(norm_floor_sq)) ||
                     (norm_b < NORM_WIDTH'(norm_floor_sq)) ||
                     (norm_a == '0) || (norm_b == '0);

  assign cand   = acc_s + acc_u + acc_v;
  assign target = {prod_d[DSQ_WIDTH-1:0], 32'd0};
  assign ok     = (cand <= target);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      norm_floor_sq <= FLOOR_RESET;
    end else if (cfg_write) begin
      norm_floor_sq <= cfg_data;
    end
  end

  // accumulators, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      dot           <= '0;
      norm_a        <= '0;
      norm_b        <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.load) begin
      dot           <= '0;
      norm_a        <= '0;
      norm_b        <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.accum) begin
      if (dot_sum[DOT_WIDTH] != dot_sum[DOT_WIDTH-1]) begin
        dot <= dot_sum[DOT_WIDTH] ? {1'b1, {(DOT_WIDTH-1){1'b0}}}
                                  : {1'b0, {(DOT_WIDTH-1){1'b1}}};
      end else begin
        dot <= dot_sum[DOT_WIDTH-1:0];
      end
      norm_a <= na_sum[NORM_WIDTH] ? '1 : na_sum[NORM_WIDTH-1:0];
      norm_b <= nb_sum[NORM_WIDTH] ? '1 : nb_sum[NORM_WIDTH-1:0];
      if ((dot_sum[DOT_WIDTH] != dot_sum[DOT_WIDTH-1]) || na_sum[NORM_WIDTH] ||
          nb_sum[NORM_WIDTH]) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // final phase: products, then root search one bit a step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mcand_d  <= dot_pos ? MCAND_WIDTH'(dot[DOT_WIDTH-2:0]) : '0;
      mplier_d <= dot_pos ? MPLIER_WIDTH'(dot[DOT_WIDTH-2:0]) : '0;
      mcand_p  <= MCAND_WIDTH'(norm_a);
      mplier_p <= MPLIER_WIDTH'(norm_b);
      prod_d   <= '0;
      prod_p   <= '0;
      degen    <= degen_now;
      zero_res <= degen_now || !dot_pos;
      sat_r    <= overflow_seen;
    end else if (cmd.mul_step) begin
      prod_d   <= prod_d + MCAND_WIDTH'(mcand_d * mplier_d[DIGIT_WIDTH-1:0]);
      prod_p   <= prod_p + MCAND_WIDTH'(mcand_p * mplier_p[DIGIT_WIDTH-1:0]);
      mcand_d  <= mcand_d << DIGIT_WIDTH;
      mcand_p  <= mcand_p << DIGIT_WIDTH;
      mplier_d <= mplier_d >> DIGIT_WIDTH;
      mplier_p <= mplier_p >> DIGIT_WIDTH;
    end
    if (cmd.root_init) begin
      acc_s <= '0;
      acc_u <= '0;
      acc_v <= {ROOT_WIDTH'(prod_p[PROD_WIDTH-1:0])} << (2 * (ROOT_STEPS - 1));
      q     <= '0;
    end else if (cmd.root_step) begin
      q     <= {q[SIM_WIDTH-2:0], ok};
      if (ok) begin
        acc_s <= cand;
      end
      acc_u <= (acc_u >> 1) + (ok ? acc_v : '0);
      acc_v <= acc_v >> 2;
    end
  end

  assign result.similarity = zero_res ? '0 : q;
  assign result.degenerate = degen;
  assign result.saturated  = sat_r;

endmodule

// File: hdl/cse_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cse_controller
// sequences accumulation and the final multiply, root and result beat
// ---------------------------------------------------------------------------
module cse_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           item_last,
  output logic           busy,
  output logic           done,
  output cse_pkg::ctrl_t cmd
);
  import cse_pkg::*;

  state_t                 state, state_next;
  logic [COUNT_WIDTH-1:0] count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    case (state)
      ST_IDLE: begin
        if (start && item_last) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_MUL;
        count_next = '0;
      end
      ST_MUL: begin
        count_next = count + 1'b1;
        if (count == COUNT_WIDTH'(MUL_STEPS - 1)) begin
          state_next = ST_RINIT;
        end
      end
      ST_RINIT: begin
        state_next = ST_ROOT;
        count_next = '0;
      end
      ST_ROOT: begin
        count_next = count + 1'b1;
        if (count == COUNT_WIDTH'(ROOT_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy          = (state != ST_IDLE);
    done          = (state == ST_DONE);
    cmd.accum     = (state == ST_IDLE) && start;
    cmd.load      = (state == ST_LOAD);
    cmd.mul_step  = (state == ST_MUL);
    cmd.root_init = (state == ST_RINIT);
    cmd.root_step = (state == ST_ROOT);
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");
  a_plain_free: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && !item_last) |=> !busy)
    else $error("non-final beat left the engine busy");

endmodule

// File: hdl/cosine_similarity_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cosine_similarity_engine
// streaming cosine similarity of two Q1.15 vectors, result in Q0.16
// ---------------------------------------------------------------------------
//  channel   signals                          direction  handshake
//  item      start, busy, item                in         start && !busy
//  config    cfg_valid, cfg_ready, cfg_data   in         cfg_valid && cfg_ready
//  result    result_valid, result             out        one-cycle strobe
//
//  a non-final beat leaves busy low so pairs stream back to back
//  the final beat holds busy through load, six 8-bit digit steps of dot squared
//  and norm_a times norm_b, root setup, 16 bitwise root search steps and the result
//  beat, in which result_valid pulses for one cycle; the receiver cannot stall
//  reset (rst, synchronous) clears accumulators and sets the floor to 11
//  the config channel is always ready; write it only while idle
// ---------------------------------------------------------------------------
module cosine_similarity_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  cse_pkg::item_t                  item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cse_pkg::FLOOR_WIDTH-1:0] cfg_data,
  output logic                            result_valid,
  output cse_pkg::result_t                result
);
  import cse_pkg::*;

  ctrl_t cmd;

  // floor register takes a write every cycle it is offered
  assign cfg_ready = 1'b1;

  // sequencer: accumulate per beat, then multiply, root and emit on the last beat
  cse_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item_last (item.last),
    .busy      (busy),
    .done      (result_valid),
    .cmd       (cmd)
  );

  // arithmetic: saturating sums, digit-serial multipliers, root search
  cse_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule
